// ===== design/fp4_block_scaled_dequant_core_macros.svh =====
// Assertion macros for the dequantizer core
`ifndef FP4_BLOCK_SCALED_DEQUANT_CORE_MACROS_SVH
`define FP4_BLOCK_SCALED_DEQUANT_CORE_MACROS_SVH

// Implication checked at every edge outside reset
`define FBSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define FBSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/fbsd_pkg.sv =====
package fbsd_pkg;

    localparam int unsigned COLUMN_PAIRS_DEF = 64;

    localparam int unsigned CMD_W    = 1;
    localparam int unsigned SIDX_W   = 7;
    localparam int unsigned SVAL_W   = 8;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PAIR_W   = 6;
    localparam int unsigned BF16_W   = 16;

    localparam logic CMD_WRITE_SCALE = 1'b0;
    localparam logic CMD_DEQUANT     = 1'b1;

    localparam logic [BF16_W-1:0] BF16_INF_MAG = 16'h7F80;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SIDX_W-1:0] scale_index;
        logic [SVAL_W-1:0] scale_value;
        logic [BYTE_W-1:0] packed_byte;
        logic [PAIR_W-1:0] pair_index;
    } t_req;

    typedef struct packed {
        logic [BF16_W-1:0] low_bf16;
        logic [BF16_W-1:0] high_bf16;
    } t_rsp;

    // Per magnitude code: exponent offset to add to the scale exponent
    function automatic logic signed [2:0] code_exp_off(input logic [2:0] mag);
        logic signed [2:0] r;
        unique case (mag)
            3'd1:       r = -3'sd1;
            3'd4, 3'd5: r = 3'sd1;
            3'd6, 3'd7: r = 3'sd2;
            default:    r = 3'sd0;
        endcase
        return r;
    endfunction

    // Build one bf16 pattern from a nibble and its E8M0 scale
    function automatic logic [BF16_W-1:0] dequant_one(input logic [3:0] nib,
                                                      input logic [7:0] scale);
        logic [2:0]        mag;
        logic              sgn;
        logic              half;
        logic signed [9:0] e;
        logic [BF16_W-1:0] r;
        mag  = nib[2:0];
        sgn  = nib[3];
        half = mag[0] & (mag != 3'd1);
        e    = $signed({2'b00, scale}) + 10'(code_exp_off(mag));
        if (mag == 3'd0)
            r = '0;
        else if (scale == 8'd0 || scale == 8'd255)
            r = {sgn, 15'd0};
        else if (e >= 10'sd255)
            r = {sgn, 15'd0} | BF16_INF_MAG;
        else if (e >= 10'sd1)
            r = {sgn, e[7:0], half, 6'd0};
        else
            r = {sgn, 8'd0, 1'b1, half, 5'd0};
        return r;
    endfunction

endpackage

// ===== design/fbsd_if.sv =====
interface fbsd_req_if;
    import fbsd_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fbsd_rsp_if;
    import fbsd_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/fbsd_scale_mem.sv =====
// Two banks (even and odd columns) so one request reads both scales
module fbsd_scale_mem #(
    parameter int unsigned COLUMN_PAIRS = fbsd_pkg::COLUMN_PAIRS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic                         i_wr,
    input  logic [fbsd_pkg::SIDX_W-1:0]  i_widx,
    input  logic [fbsd_pkg::SVAL_W-1:0]  i_wval,
    input  logic [fbsd_pkg::PAIR_W-1:0]  i_pair,
    output logic [fbsd_pkg::SVAL_W-1:0]  o_s0,
    output logic [fbsd_pkg::SVAL_W-1:0]  o_s1
);
    import fbsd_pkg::*;
    localparam int unsigned AW = (COLUMN_PAIRS > 1) ? $clog2(COLUMN_PAIRS) : 1;

    logic [SVAL_W-1:0] r_even [COLUMN_PAIRS];
    logic [SVAL_W-1:0] r_odd  [COLUMN_PAIRS];
    logic [AW-1:0]     w_addr;
    logic [AW-1:0]     r_addr;
    logic              w_ok;
    logic              r_ok;
    logic [SIDX_W:0]   w_pair;

    always_comb begin
        w_pair = {1'b0, i_widx} >> 1;
        w_ok   = 32'(w_pair) < COLUMN_PAIRS;
        r_ok   = 32'(i_pair) < COLUMN_PAIRS;
        w_addr = AW'(w_pair);
        r_addr = AW'(i_pair);
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_en && i_wr && w_ok) begin
            if (i_widx[0]) r_odd[w_addr]  <= i_wval;
            else           r_even[w_addr] <= i_wval;
        end
    end

    // Registered read; out-of-range pair reads zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_s0 <= r_ok ? r_even[r_addr] : '0;
            o_s1 <= r_ok ? r_odd[r_addr]  : '0;
        end
    end
endmodule

// ===== design/fp4_block_scaled_dequant_core.sv =====
// FP4 E2M1 to bfloat16 dequantizer with per-column E8M0 scales. A request with
// command 0 stores one scale byte and yields no result; command 1 takes a packed
// byte and yields both bf16 values. One request is accepted every cycle while
// the output is not stalled; a result passes through the scale read, convert
// and output registers. A write is visible to a dequant request accepted in the
// following cycle or later. Back-pressure stalls all stages together.
module fp4_block_scaled_dequant_core #(
    parameter int unsigned COLUMN_PAIRS = fbsd_pkg::COLUMN_PAIRS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fbsd_req_if.sink        i_req,
    fbsd_rsp_if.source      o_rsp
);
    import fbsd_pkg::*;
    `include "fp4_block_scaled_dequant_core_macros.svh"

    logic              adv;
    logic              r_v1, r_v2, r_v3;
    logic [BYTE_W-1:0] r_b1;
    logic [SVAL_W-1:0] s0, s1;
    t_rsp              r_out;
    logic              acc_dq;

    // Whole pipe moves when the output slot is free or being drained
    assign adv         = !r_v3 || o_rsp.ready;
    assign i_req.ready = adv;
    assign acc_dq      = i_req.valid && i_req.data.command == CMD_DEQUANT;

    fbsd_scale_mem #(.COLUMN_PAIRS(COLUMN_PAIRS)) u_mem (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_wr  (i_req.valid && i_req.data.command == CMD_WRITE_SCALE),
        .i_widx(i_req.data.scale_index),
        .i_wval(i_req.data.scale_value),
        .i_pair(i_req.data.pair_index),
        .o_s0  (s0),
        .o_s1  (s1)
    );

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= acc_dq;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Payload: byte beside memory read, then conversion, then output
    t_rsp r_cv;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1  <= i_req.data.packed_byte;
            r_cv  <= '{low_bf16:  dequant_one(r_b1[3:0], s0),
                       high_bf16: dequant_one(r_b1[7:4], s1)};
            r_out <= r_cv;
        end
    end

    assign o_rsp.valid = r_v3;
    assign o_rsp.data  = r_out;

    `FBSD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_v3 && !o_rsp.ready, r_v3 && $stable(r_out))
    `FBSD_ASSERT_NEXT(a_write_no_rsp, i_clk, i_rst_n,
        adv && i_req.valid && i_req.data.command == CMD_WRITE_SCALE, !r_v1)
    `FBSD_ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !r_v3, i_req.ready)
endmodule
